// File: rtl/sdbr_pkg.sv
`timescale 1ns / 1ps
// Package for the cache replacement policy block: transaction structs,
// controller/datapath command and status structs, fixed constants. No dependencies.
package sdbr_pkg;

  localparam int unsigned RRPV_W = 2;
  localparam int unsigned SIG_BITS = 6;
  localparam logic [1:0] RRPV_MAX = 2'd3;
  localparam int unsigned ADDR_W = 48;
  localparam logic [ADDR_W-1:0] STRIDE_ONE = 48'd64;
  localparam logic [ADDR_W-1:0] STRIDE_TWO = 48'd128;
  localparam int unsigned MASK_WAYS = 16;
  localparam logic [6:0] NEAR_PCT_RESET = 7'd5;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [15:0] valid_mask;
    logic [47:0] phys_addr;
    logic [47:0] pc;
    logic        hit;
    logic [6:0]  random_draw;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] inserted_rrpv;
    logic       bypassed;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic victim;
    logic stride;
    logic adjust;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic operation;
  } sts_t;

endpackage

// File: rtl/ship_drrip_stream_bypass_replacement.sv
`timescale 1ns / 1ps
// Top level of the replacement policy block: controller plus datapath.
// Depends on sdbr_pkg, sdbr_ctrl, sdbr_dp.
//
//   channel   signals                 direction  transaction
//   request   start, busy, req        in         start && !busy
//   result    done, rsp               out        done (one cycle, no stall)
//   config    cfg_we, cfg_wdata       in         cfg_we
//
// A victim request goes from accept through the read state to done. An update
// does row read, stride write and reuse read, reuse write, row write-back in order,
// all through single-port set metadata memories. After reset a clearing pass over
// max(SETS, SIGNATURE_ENTRIES) entries holds busy high. The receiver cannot stall.
module ship_drrip_stream_bypass_replacement #(
  parameter int unsigned SETS = 2048,
  parameter int unsigned WAYS = 16,
  parameter int unsigned LEADER_SETS = 32,
  parameter int unsigned SIGNATURE_ENTRIES = 64,
  parameter int unsigned SELECTOR_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sdbr_pkg::req_t req,
  output logic           done,
  output sdbr_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [6:0]     cfg_wdata
);

  sdbr_pkg::cmd_t cmd;
  sdbr_pkg::sts_t sts;

  sdbr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  sdbr_dp #(
    .SETS              (SETS),
    .WAYS              (WAYS),
    .LEADER_SETS       (LEADER_SETS),
    .SIGNATURE_ENTRIES (SIGNATURE_ENTRIES),
    .SELECTOR_BITS     (SELECTOR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

// File: rtl/sdbr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the replacement policy block.
// Depends on sdbr_pkg (cmd_t, sts_t, operation codes).
module sdbr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sdbr_pkg::sts_t sts,
  output sdbr_pkg::cmd_t cmd,
  output logic           busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_REUSE,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: if (sts.clear_last) state <= S_IDLE;
        S_IDLE: if (start) state <= S_READ;
        S_READ: begin
          if (sts.operation == sdbr_pkg::OP_VICTIM) state <= S_IDLE;
          else state <= S_REUSE;
        end
        S_REUSE: state <= S_FINISH;
        S_FINISH: state <= S_IDLE;
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.clear  = (state == S_CLEAR);
    cmd.load   = (state == S_IDLE) && start;
    cmd.victim = (state == S_READ) && (sts.operation == sdbr_pkg::OP_VICTIM);
    cmd.stride = (state == S_READ) && (sts.operation == sdbr_pkg::OP_UPDATE);
    cmd.adjust = (state == S_REUSE);
    cmd.finish = (state == S_FINISH);
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/sdbr_dp.sv
`timescale 1ns / 1ps
// Datapath: set metadata memories, reuse counters, stride tracker, selector, result register.
// Depends on sdbr_pkg.
module sdbr_dp #(
  parameter int unsigned SETS = 2048,
  parameter int unsigned WAYS = 16,
  parameter int unsigned LEADER_SETS = 32,
  parameter int unsigned SIGNATURE_ENTRIES = 64,
  parameter int unsigned SELECTOR_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  sdbr_pkg::cmd_t cmd,
  input  sdbr_pkg::req_t req,
  input  logic           cfg_we,
  input  logic [6:0]     cfg_wdata,
  output sdbr_pkg::sts_t sts,
  output logic           done,
  output sdbr_pkg::rsp_t rsp
);

  localparam int unsigned SET_W = $clog2(SETS);
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SIG_W = $clog2(SIGNATURE_ENTRIES);
  localparam int unsigned CLR_N = (SETS > SIGNATURE_ENTRIES) ? SETS : SIGNATURE_ENTRIES;
  localparam int unsigned CLR_W = $clog2(CLR_N);
  localparam int unsigned ROW_R = sdbr_pkg::RRPV_W * WAYS;
  localparam int unsigned ROW_S = sdbr_pkg::SIG_BITS * WAYS;
  localparam int unsigned HALF = SETS / 2;
  localparam logic [SELECTOR_BITS-1:0] SEL_MID = {1'b1, {(SELECTOR_BITS-1){1'b0}}};
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;

  logic [ROW_R-1:0] rrpv_mem [SETS];
  logic [ROW_S-1:0] sig_mem [SETS];
  logic [sdbr_pkg::ADDR_W+1:0] stride_mem [SETS];
  logic [1:0] reuse_mem [SIGNATURE_ENTRIES];

  logic [CLR_W-1:0] clr_cnt;
  logic [6:0] near_pct;
  logic [SELECTOR_BITS-1:0] selector;
  sdbr_pkg::req_t rq;
  logic [SET_W-1:0] set_a, load_set;
  logic [ROW_R-1:0] rrpv_q;
  logic [ROW_S-1:0] sig_q;
  logic [sdbr_pkg::ADDR_W+1:0] stride_q;
  logic [1:0] reuse_q;
  logic streaming;
  logic [SIG_W-1:0] mod_addr;
  logic [1:0] mod_val;

  assign load_set = SET_W'(req.set_index);
  assign set_a = SET_W'(rq.set_index);

  logic [WAY_W-1:0] way;
  logic [sdbr_pkg::SIG_BITS-1:0] sig_new, sig_old;
  logic [SIG_W-1:0] idx, old_idx;

  assign way = WAY_W'(rq.way_index);
  assign sig_new = rq.pc[7:2];
  assign sig_old = sig_q[way*sdbr_pkg::SIG_BITS +: sdbr_pkg::SIG_BITS];
  assign idx = SIG_W'(sig_new);
  assign old_idx = SIG_W'(sig_old);

  // victim search
  logic [1:0] top, gap;
  logic [ROW_R-1:0] aged;
  logic [WAY_W-1:0] inv_way, max_way;
  logic inv_found, max_found;
  logic [3:0] vway;

  always_comb begin
    top = 2'd0;
    for (int w = 0; w < WAYS; w++) begin
      if (rrpv_q[w*2 +: 2] > top) top = rrpv_q[w*2 +: 2];
    end
    gap = sdbr_pkg::RRPV_MAX - top;
    for (int w = 0; w < WAYS; w++) begin
      aged[w*2 +: 2] = rrpv_q[w*2 +: 2] + gap;
    end
    inv_found = 1'b0;
    inv_way = '0;
    max_found = 1'b0;
    max_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (w < sdbr_pkg::MASK_WAYS) begin
        if (!rq.valid_mask[w]) begin
          inv_found = 1'b1;
          inv_way = WAY_W'(w);
        end
      end
      if (aged[w*2 +: 2] == sdbr_pkg::RRPV_MAX) begin
        max_found = 1'b1;
        max_way = WAY_W'(w);
      end
    end
    if (inv_found) vway = 4'(inv_way);
    else if (max_found) vway = 4'(max_way);
    else vway = 4'd0;
  end

  // stride tracker
  logic [sdbr_pkg::ADDR_W-1:0] prev, delta;
  logic [1:0] score, score_next;

  assign prev = stride_q[sdbr_pkg::ADDR_W+1:2];
  assign score = stride_q[1:0];

  always_comb begin
    delta = (rq.phys_addr > prev) ? rq.phys_addr - prev : prev - rq.phys_addr;
    if (prev == '0) score_next = 2'd0;
    else if (delta == sdbr_pkg::STRIDE_ONE || delta == sdbr_pkg::STRIDE_TWO)
      score_next = (score == 2'd3) ? score : score + 2'd1;
    else score_next = (score == 2'd0) ? score : score - 2'd1;
  end

  // insertion
  logic srrip_ld, brrip_ld, brrip, bypass;
  logic [1:0] cur, depth;
  logic [ROW_R-1:0] rrpv_row;
  logic [ROW_S-1:0] sig_row;

  always_comb begin
    srrip_ld = (32'(set_a) < LEADER_SETS);
    brrip_ld = (32'(set_a) >= HALF) && (32'(set_a) < HALF + LEADER_SETS);
    if (srrip_ld) brrip = 1'b0;
    else if (brrip_ld) brrip = 1'b1;
    else brrip = (selector >= SEL_MID);
    cur = (mod_addr == idx) ? mod_val : reuse_q;
    depth = 2'd2;
    if (brrip && (rq.random_draw < near_pct)) depth = 2'd1;
    if (cur >= 2'd2) depth = 2'd0;
    bypass = 1'b0;
    if (streaming) begin
      depth = sdbr_pkg::RRPV_MAX;
      bypass = (cur == 2'd0);
    end
    rrpv_row = rrpv_q;
    rrpv_row[way*2 +: 2] = depth;
    sig_row = sig_q;
    sig_row[way*sdbr_pkg::SIG_BITS +: sdbr_pkg::SIG_BITS] = sig_new;
  end

  assign sts.clear_last = (clr_cnt == CLR_W'(CLR_N - 1));
  assign sts.operation = rq.operation;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      near_pct <= sdbr_pkg::NEAR_PCT_RESET;
      selector <= SEL_MID;
      done <= 1'b0;
    end else begin
      done <= cmd.victim || cmd.finish;
      if (cfg_we) near_pct <= cfg_wdata;
      if (cmd.clear) clr_cnt <= clr_cnt + CLR_W'(1);
      if (cmd.finish && rq.hit && !bypass) begin
        if (srrip_ld) begin
          if (selector != SEL_MAX) selector <= selector + SELECTOR_BITS'(1);
        end else if (brrip_ld) begin
          if (selector != '0) selector <= selector - SELECTOR_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      if (32'(clr_cnt) < SETS) begin
        rrpv_mem[clr_cnt[SET_W-1:0]] <= '1;
        sig_mem[clr_cnt[SET_W-1:0]] <= '0;
        stride_mem[clr_cnt[SET_W-1:0]] <= '0;
      end
      if (32'(clr_cnt) < SIGNATURE_ENTRIES) reuse_mem[clr_cnt[SIG_W-1:0]] <= 2'd1;
    end
    if (cmd.load) begin
      rq <= req;
      rrpv_q <= rrpv_mem[load_set];
      sig_q <= sig_mem[load_set];
      stride_q <= stride_mem[load_set];
    end
    if (cmd.victim) begin
      // set ages only when every way is valid
      if (!inv_found) rrpv_mem[set_a] <= aged;
      rsp.victim_way <= vway;
      rsp.inserted_rrpv <= 2'd0;
      rsp.bypassed <= 1'b0;
    end
    if (cmd.stride) begin
      stride_mem[set_a] <= {rq.phys_addr, score_next};
      streaming <= (score_next >= 2'd2);
      reuse_q <= reuse_mem[rq.hit ? idx : old_idx];
    end
    if (cmd.adjust) begin
      if (rq.hit) begin
        mod_addr <= idx;
        mod_val <= (reuse_q == 2'd3) ? reuse_q : reuse_q + 2'd1;
        reuse_mem[idx] <= (reuse_q == 2'd3) ? reuse_q : reuse_q + 2'd1;
      end else begin
        mod_addr <= old_idx;
        mod_val <= (reuse_q == 2'd0) ? reuse_q : reuse_q - 2'd1;
        reuse_mem[old_idx] <= (reuse_q == 2'd0) ? reuse_q : reuse_q - 2'd1;
      end
      reuse_q <= reuse_mem[idx];
    end
    if (cmd.finish) begin
      rrpv_mem[set_a] <= rrpv_row;
      sig_mem[set_a] <= sig_row;
      rsp.victim_way <= 4'd0;
      rsp.inserted_rrpv <= depth;
      rsp.bypassed <= bypass;
    end
  end

endmodule

// File: tb/sv/ship_drrip_stream_bypass_replacement_tb.sv
`timescale 1ns / 1ps
// Testbench for the cache replacement policy block: directed and random victim/update
// transactions checked against an in-bench policy predictor. Uses sdbr_pkg, the DUT.
module ship_drrip_stream_bypass_replacement_tb;

  localparam int NSETS = 2048;
  localparam int NWAYS = 16;
  localparam int NLEAD = 32;
  localparam int NSIG = 64;
  localparam int SEL_TOP = 1023;
  localparam int SEL_HALF = 512;
  localparam int STALL_LIMIT = 20000;

  class policy_scoreboard;
    logic [6:0]  near_pct;
    logic [1:0]  rrpv [NSETS*NWAYS];
    logic [5:0]  sig_of [NSETS*NWAYS];
    logic [1:0]  reuse [NSIG];
    logic [47:0] prev_addr [NSETS];
    logic [1:0]  score [NSETS];
    int          selector;
    sdbr_pkg::rsp_t pending [$];
    int          errors;

    function void clear_state();
      foreach (rrpv[i]) begin
        rrpv[i] = sdbr_pkg::RRPV_MAX;
        sig_of[i] = '0;
      end
      foreach (reuse[i]) reuse[i] = 2'd1;
      foreach (prev_addr[i]) begin
        prev_addr[i] = '0;
        score[i] = '0;
      end
      selector = SEL_HALF;
      near_pct = sdbr_pkg::NEAR_PCT_RESET;
      errors = 0;
    endfunction

    function void note_request(sdbr_pkg::req_t r);
      int s, base, line, top, sig, old;
      logic [47:0] d;
      logic [1:0] depth;
      bit brrip, streaming;
      sdbr_pkg::rsp_t e;
      e = '0;
      s = r.set_index;
      base = s * NWAYS;
      if (r.operation == sdbr_pkg::OP_VICTIM) begin
        e.victim_way = 4'hF;
        for (int w = 0; w < NWAYS; w++)
          if (!r.valid_mask[w]) begin
            e.victim_way = w[3:0];
            break;
          end
        if (e.victim_way == 4'hF && r.valid_mask[15]) begin
          top = 0;
          for (int w = 0; w < NWAYS; w++) if (rrpv[base+w] > top) top = rrpv[base+w];
          if (top < 3)
            for (int w = 0; w < NWAYS; w++) rrpv[base+w] = 2'(rrpv[base+w] + (3 - top));
          e.victim_way = 4'd0;
          for (int w = 0; w < NWAYS; w++)
            if (rrpv[base+w] == sdbr_pkg::RRPV_MAX) begin
              e.victim_way = w[3:0];
              break;
            end
        end
        pending.push_back(e);
        return;
      end
      if (prev_addr[s] == 0) score[s] = 2'd0;
      else begin
        d = (r.phys_addr > prev_addr[s]) ? r.phys_addr - prev_addr[s]
                                         : prev_addr[s] - r.phys_addr;
        if (d == sdbr_pkg::STRIDE_ONE || d == sdbr_pkg::STRIDE_TWO) begin
          if (score[s] < 3) score[s]++;
        end else if (score[s] > 0) score[s]--;
      end
      prev_addr[s] = r.phys_addr;
      streaming = score[s] >= 2;
      line = base + r.way_index;
      sig = r.pc[7:2];
      if (r.hit) begin
        rrpv[line] = 2'd0;
        if (reuse[sig] < 3) reuse[sig]++;
      end else begin
        old = sig_of[line];
        if (reuse[old] > 0) reuse[old]--;
      end
      sig_of[line] = 6'(sig);
      if (s < NLEAD) brrip = 1'b0;
      else if (s >= NSETS/2 && s < NSETS/2 + NLEAD) brrip = 1'b1;
      else brrip = selector >= SEL_HALF;
      depth = 2'd2;
      if (brrip && r.random_draw < near_pct) depth = 2'd1;
      if (reuse[sig] >= 2) depth = 2'd0;
      if (streaming) begin
        depth = sdbr_pkg::RRPV_MAX;
        if (reuse[sig] == 0) begin
          rrpv[line] = sdbr_pkg::RRPV_MAX;
          e.inserted_rrpv = sdbr_pkg::RRPV_MAX;
          e.bypassed = 1'b1;
          pending.push_back(e);
          return;
        end
      end
      rrpv[line] = depth;
      e.inserted_rrpv = depth;
      if (r.hit) begin
        if (s < NLEAD) begin
          if (selector < SEL_TOP) selector++;
        end else if (s >= NSETS/2 && s < NSETS/2 + NLEAD) begin
          if (selector > 0) selector--;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(sdbr_pkg::rsp_t got);
      sdbr_pkg::rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.victim_way !== e.victim_way) begin
        $error("victim_way exp %0d got %0d", e.victim_way, got.victim_way);
        errors++;
      end
      if (got.inserted_rrpv !== e.inserted_rrpv) begin
        $error("inserted_rrpv exp %0d got %0d", e.inserted_rrpv, got.inserted_rrpv);
        errors++;
      end
      if (got.bypassed !== e.bypassed) begin
        $error("bypassed exp %0d got %0d", e.bypassed, got.bypassed);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, cfg_we;
  logic [6:0] cfg_wdata;
  sdbr_pkg::req_t req;
  sdbr_pkg::rsp_t rsp;
  policy_scoreboard sb;
  int idle_pct;
  int quiet_cycles;
  logic [47:0] stream_addr [8];
  logic [10:0] hot_set [8];

  ship_drrip_stream_bypass_replacement u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) quiet_cycles <= 0;
    else if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (!rst && done) sb.check_result(rsp);
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ship_drrip_stream_bypass_replacement regression: fail");
      $finish;
    end
  end

  task automatic send(sdbr_pkg::req_t r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_near(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.near_pct = v;
  endtask

  function automatic sdbr_pkg::req_t rand_req();
    sdbr_pkg::req_t r;
    int k;
    r = '0;
    k = $urandom_range(7);
    r.operation = $urandom_range(99) < 65 ? sdbr_pkg::OP_UPDATE : sdbr_pkg::OP_VICTIM;
    r.way_index = 4'($urandom);
    r.valid_mask = ($urandom_range(3) != 0) ? 16'hFFFF : 16'($urandom);
    r.hit = 1'($urandom);
    r.random_draw = ($urandom_range(19) == 0) ? 7'($urandom) : 7'($urandom_range(99));
    r.pc = 48'({$urandom, $urandom});
    if ($urandom_range(3) != 0) r.pc[7:2] = 6'($urandom_range(7));
    if ($urandom_range(9) < 7) begin
      r.set_index = hot_set[k];
      if (r.operation == sdbr_pkg::OP_UPDATE) begin
        stream_addr[k] = stream_addr[k] + ($urandom_range(9) == 0 ? 48'($urandom) :
                          ($urandom_range(1) ? sdbr_pkg::STRIDE_ONE : sdbr_pkg::STRIDE_TWO));
      end
      r.phys_addr = stream_addr[k];
    end else begin
      r.set_index = 11'($urandom);
      r.phys_addr = 48'({$urandom, $urandom});
    end
    return r;
  endfunction

  initial begin
    sdbr_pkg::req_t r;
    int phase_idle [4];
    logic [6:0] pct_set [4];
    phase_idle = '{0, 79, 0, 6};
    pct_set = '{7'd0, 7'd100, 7'd127, 7'd50};
    sb = new();
    sb.clear_state();
    start = 0;
    req = '0;
    cfg_we = 0;
    cfg_wdata = '0;
    idle_pct = 0;
    rst = 1;
    foreach (stream_addr[i]) stream_addr[i] = 48'({$urandom, $urandom}) | 48'h1;
    hot_set = '{11'd0, 11'd5, 11'd1024, 11'd1030, 11'd2047, 11'd700, 11'd33, 11'd1056};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    r = '0; r.operation = sdbr_pkg::OP_VICTIM; r.valid_mask = 16'hFFFF; send(r);
    r.valid_mask = 16'h7FFF; send(r);
    r.valid_mask = 16'h0000; r.set_index = 11'h7FF; send(r);
    r = '0; r.operation = sdbr_pkg::OP_UPDATE; r.set_index = 11'd3; r.way_index = 4'hF;
    r.pc = 48'hFFFF_FFFF_FFFF; r.phys_addr = 48'hFFFF_FFFF_FFC0; r.hit = 1'b1;
    r.random_draw = 7'h7F; send(r);
    for (int i = 0; i < 4; i++) begin
      r.phys_addr = r.phys_addr - ((i & 1) ? sdbr_pkg::STRIDE_TWO : sdbr_pkg::STRIDE_ONE);
      r.hit = i[0]; r.pc[7:2] = 6'd0; r.way_index = 4'(i); send(r);
    end
    r = '0; r.operation = sdbr_pkg::OP_UPDATE; r.set_index = 11'd1024; r.phys_addr = 48'h1000;
    r.random_draw = 7'd0; r.hit = 1'b1; send(r);
    r.set_index = 11'd1500; r.hit = 1'b0; r.random_draw = 7'd99; send(r);
    r.set_index = 11'd31; r.hit = 1'b1; send(r);
    r = '0; r.operation = sdbr_pkg::OP_VICTIM; r.set_index = 11'd3; r.valid_mask = 16'hFFFF;
    send(r);

    for (int p = 0; p < 4; p++) begin
      write_near(pct_set[p]);
      idle_pct = phase_idle[p];
      for (int i = 0; i < 235; i++) send(rand_req());
    end
    write_near(sdbr_pkg::NEAR_PCT_RESET);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("ship_drrip_stream_bypass_replacement regression: pass");
    else
      $display("ship_drrip_stream_bypass_replacement regression: fail");
    $finish;
  end
endmodule

// File: ship_drrip_stream_bypass_replacement.f
rtl/sdbr_pkg.sv
rtl/sdbr_ctrl.sv
rtl/sdbr_dp.sv
rtl/ship_drrip_stream_bypass_replacement.sv
tb/sv/ship_drrip_stream_bypass_replacement_tb.sv
